// ----- rtl/core/sosb_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sosb_pkg
// Types, constants and segment helpers for the status LED SOS blinker.
// ----------------------------------------------------------------------------
package sosb_pkg;

  typedef enum logic [1:0] {
    MODE_BOOTING = 2'd0,
    MODE_READY   = 2'd1,
    MODE_NODEV   = 2'd2,
    MODE_FAULT   = 2'd3
  } mode_t;

  localparam logic ACT_TICK = 1'b0;
  localparam logic ACT_SET  = 1'b1;

  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_DOT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DASH   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMGAP = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TAIL   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TOGGLE = 3'd5;

  localparam logic [CFG_W-1:0] DOT_RST    = 16'd150;
  localparam logic [CFG_W-1:0] DASH_RST   = 16'd450;
  localparam logic [CFG_W-1:0] SYMGAP_RST = 16'd150;
  localparam logic [CFG_W-1:0] WORD_RST   = 16'd700;
  localparam logic [CFG_W-1:0] TAIL_RST   = 16'd2000;
  localparam logic [CFG_W-1:0] TOGGLE_RST = 16'd1000;

  localparam int MARKS_PER_LETTER = 3;
  localparam int SEGS_PER_LETTER  = 2 * MARKS_PER_LETTER + 1;
  localparam int SEGS_PER_CYCLE   = 3 * SEGS_PER_LETTER;
  localparam int SEG_W            = $clog2(SEGS_PER_CYCLE);

  typedef logic [SEG_W-1:0] seg_t;

  typedef struct packed {
    logic [CFG_W-1:0] dot;
    logic [CFG_W-1:0] dash;
    logic [CFG_W-1:0] symgap;
    logic [CFG_W-1:0] word;
    logic [CFG_W-1:0] tail;
  } sos_cfg_t;

  function automatic logic [CFG_W-1:0] at_least_one(logic [CFG_W-1:0] v);
    return (v == '0) ? CFG_W'(1) : v;
  endfunction

  // letter index 0..2 of a segment
  function automatic logic [1:0] seg_letter(seg_t seg);
    logic [1:0] l;
    if ({1'b0, seg} < (SEG_W + 1)'(SEGS_PER_LETTER)) begin
      l = 2'd0;
    end else if ({1'b0, seg} < (SEG_W + 1)'(2 * SEGS_PER_LETTER)) begin
      l = 2'd1;
    end else begin
      l = 2'd2;
    end
    return l;
  endfunction

  // position within the letter
  function automatic seg_t seg_pos(seg_t seg);
    logic [1:0] l;
    seg_t       p;
    l = seg_letter(seg);
    case (l)
      2'd0:    p = seg;
      2'd1:    p = seg - SEG_W'(SEGS_PER_LETTER);
      default: p = seg - SEG_W'(2 * SEGS_PER_LETTER);
    endcase
    return p;
  endfunction

  function automatic logic seg_lit(seg_t seg);
    seg_t p;
    p = seg_pos(seg);
    return ({1'b0, p} < (SEG_W + 1)'(2 * MARKS_PER_LETTER)) && !p[0];
  endfunction

  function automatic logic [CFG_W-1:0] seg_len(seg_t seg, sos_cfg_t c);
    seg_t             p;
    logic [1:0]       l;
    logic [CFG_W-1:0] len;
    p = seg_pos(seg);
    l = seg_letter(seg);
    if ({1'b0, p} < (SEG_W + 1)'(2 * MARKS_PER_LETTER)) begin
      if (!p[0]) begin
        len = (l == 2'd1) ? at_least_one(c.dash) : at_least_one(c.dot);
      end else begin
        len = at_least_one(c.symgap);
      end
    end else begin
      len = (l < 2'd2) ? c.word : c.tail;
    end
    return len;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/status_led_mode_sos_blinker_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// the result of an accepted input transaction is registered and appears on m_axis in the next cycle
// throughput: one item per cycle; s_axis_tready is high while the output register
// is empty or being drained, so input stalls only while m_axis_tready is held low
// reset (rst, synchronous): booting mode, LED lit, no SOS cycle, registers at
// their default timings
// ----------------------------------------------------------------------------
// status_led_mode_sos_blinker_top
// Four-mode status LED driver with steady, toggle and Morse SOS patterns.
// ----------------------------------------------------------------------------
module status_led_mode_sos_blinker_top (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [sosb_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [sosb_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [7:0]                    s_axis_tdata,  // [1:0] new_mode
  input  wire logic                          s_axis_tuser,  // [0] action
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [7:0]                         m_axis_tdata   // [0] led_on, [2:1] shown_mode,
                                                            // [3] sos_busy
);

  sosb_pkg::sos_cfg_t                cfg;
  logic [sosb_pkg::CFG_W-1:0]        toggle_period;

  sosb_pkg::mode_t                   requested_mode, requested_mode_next;
  sosb_pkg::mode_t                   shown_mode, shown_mode_next;
  logic                              led_level, led_level_next;
  sosb_pkg::seg_t                    sos_segment, sos_segment_next;
  logic                              sos_active, sos_active_next;
  logic [sosb_pkg::CFG_W-1:0]        tick_count, tick_count_next;

  logic                              in_fire;
  logic                              do_enter;
  sosb_pkg::mode_t                   enter_mode;
  logic [sosb_pkg::CFG_W-1:0]        cur_len;
  logic [sosb_pkg::CFG_W:0]          cnt_inc;
  logic [sosb_pkg::SEG_W:0]          seg_n1, seg_n2;

  assign s_axis_tready = !m_axis_tvalid || m_axis_tready;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dot       <= sosb_pkg::DOT_RST;
      cfg.dash      <= sosb_pkg::DASH_RST;
      cfg.symgap    <= sosb_pkg::SYMGAP_RST;
      cfg.word      <= sosb_pkg::WORD_RST;
      cfg.tail      <= sosb_pkg::TAIL_RST;
      toggle_period <= sosb_pkg::TOGGLE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        sosb_pkg::REG_DOT:    cfg.dot       <= cfg_data;
        sosb_pkg::REG_DASH:   cfg.dash      <= cfg_data;
        sosb_pkg::REG_SYMGAP: cfg.symgap    <= cfg_data;
        sosb_pkg::REG_WORD:   cfg.word      <= cfg_data;
        sosb_pkg::REG_TAIL:   cfg.tail      <= cfg_data;
        sosb_pkg::REG_TOGGLE: toggle_period <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    requested_mode_next = requested_mode;
    shown_mode_next     = shown_mode;
    led_level_next      = led_level;
    sos_segment_next    = sos_segment;
    sos_active_next     = sos_active;
    tick_count_next     = tick_count;
    do_enter            = 1'b0;
    enter_mode          = requested_mode;
    cur_len             = sosb_pkg::seg_len(sos_segment, cfg);
    cnt_inc             = {1'b0, tick_count} + (sosb_pkg::CFG_W + 1)'(1);
    seg_n1              = {1'b0, sos_segment} + (sosb_pkg::SEG_W + 1)'(1);
    seg_n2              = seg_n1 + (sosb_pkg::SEG_W + 1)'(1);

    if (in_fire) begin
      if (s_axis_tuser == sosb_pkg::ACT_SET) begin
        requested_mode_next = sosb_pkg::mode_t'(s_axis_tdata[1:0]);
        if (!sos_active) begin
          do_enter   = 1'b1;
          enter_mode = sosb_pkg::mode_t'(s_axis_tdata[1:0]);
        end
      end else if (sos_active) begin
        if (cnt_inc >= {1'b0, cur_len}) begin
          if (seg_n1 >= (sosb_pkg::SEG_W + 1)'(sosb_pkg::SEGS_PER_CYCLE)) begin
            do_enter = 1'b1;
          end else if (sosb_pkg::seg_len(seg_n1[sosb_pkg::SEG_W-1:0], cfg) == '0) begin
            // empty gap is skipped
            if (seg_n2 >= (sosb_pkg::SEG_W + 1)'(sosb_pkg::SEGS_PER_CYCLE)) begin
              do_enter = 1'b1;
            end else begin
              sos_segment_next = seg_n2[sosb_pkg::SEG_W-1:0];
              tick_count_next  = '0;
              led_level_next   = sosb_pkg::seg_lit(seg_n2[sosb_pkg::SEG_W-1:0]);
            end
          end else begin
            sos_segment_next = seg_n1[sosb_pkg::SEG_W-1:0];
            tick_count_next  = '0;
            led_level_next   = sosb_pkg::seg_lit(seg_n1[sosb_pkg::SEG_W-1:0]);
          end
        end else begin
          tick_count_next = cnt_inc[sosb_pkg::CFG_W-1:0];
        end
      end else if (shown_mode == sosb_pkg::MODE_NODEV) begin
        if (cnt_inc >= {1'b0, sosb_pkg::at_least_one(toggle_period)}) begin
          led_level_next  = !led_level;
          tick_count_next = '0;
        end else begin
          tick_count_next = cnt_inc[sosb_pkg::CFG_W-1:0];
        end
      end
    end

    if (do_enter) begin
      shown_mode_next  = enter_mode;
      tick_count_next  = '0;
      sos_active_next  = 1'b0;
      sos_segment_next = '0;
      case (enter_mode)
        sosb_pkg::MODE_BOOTING: led_level_next = 1'b1;
        sosb_pkg::MODE_READY:   led_level_next = 1'b0;
        sosb_pkg::MODE_NODEV:   led_level_next = !led_level;
        default: begin
          sos_active_next = 1'b1;
          led_level_next  = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      requested_mode <= sosb_pkg::MODE_BOOTING;
      shown_mode     <= sosb_pkg::MODE_BOOTING;
      led_level      <= 1'b1;
      sos_segment    <= '0;
      sos_active     <= 1'b0;
      tick_count     <= '0;
      m_axis_tvalid  <= 1'b0;
    end else begin
      requested_mode <= requested_mode_next;
      shown_mode     <= shown_mode_next;
      led_level      <= led_level_next;
      sos_segment    <= sos_segment_next;
      sos_active     <= sos_active_next;
      tick_count     <= tick_count_next;
      if (in_fire) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (in_fire) begin
      m_axis_tdata <= {4'b0000, sos_active_next, shown_mode_next, led_level_next};
    end
  end

endmodule
`default_nettype wire
